// ===== rtl/core/safo_pkg.sv =====
// shared types and constants for the suffix automaton first-occurrence block
`default_nettype none
package safo_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int ALPHABET = 26;
    localparam int NODE_CAP = 2 * MAX_TEXT;
    localparam int NW       = $clog2(NODE_CAP);       // node index width
    localparam int CW       = NW + 1;                 // node count width
    localparam int SW       = 5;                      // symbol / slot index width
    localparam int TAW      = NW + SW;                // transition address width
    localparam int LW       = 13;                     // length width
    localparam int EW       = 12;                     // end position width
    localparam int PW       = 13;                     // pattern length / position width

    localparam logic [SW-1:0] IDX_LAST  = SW'(ALPHABET - 1);
    localparam logic [SW-1:0] IDX_COPY  = SW'(ALPHABET);
    localparam logic [SW-1:0] SYM_LIMIT = SW'(ALPHABET);
    localparam logic [LW-1:0] TEXT_CAP  = LW'(MAX_TEXT);
    localparam logic [CW-1:0] CNT_CAP   = CW'(NODE_CAP);
    localparam logic [PW-1:0] PLEN_MAX  = PW'(8191);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_PATTERN = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_A_LEN, S_A_ZERO, S_W1_RD, S_W1_CHK, S_W1_LINK,
        S_Q_CHK, S_C_COPY, S_W2_RD, S_W2_CHK, S_W2_LINK, S_FIX_Q, S_FIX_CUR,
        S_P_CHK, S_P_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_ACCEPT, OP_SET_OVF, OP_A_INIT, OP_A_LEN, OP_A_ZERO,
        OP_W_RD, OP_W1_SET, OP_Q_RD, OP_P_LINK, OP_LINK_CUR_Q, OP_C_INIT,
        OP_C_COPY, OP_W2_SET, OP_FIX_Q, OP_FIX_CUR, OP_P_START, OP_P_NEXT,
        OP_P_OUT
    } t_op;

    typedef struct packed {
        t_action act;
        logic    full;
        logic    sym_bad;
        logic    is_last;
        logic    idx_last;
        logic    copy_done;
        logic    tr_zero;
        logic    tr_is_q;
        logic    p_root;
        logic    len_match;
        logic    out_busy;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/core/safo_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module safo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/safo_dp.sv =====
// datapath: automaton stores, walk registers, query state and result register
`default_nettype none
module safo_dp import safo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op         i_op,
    output t_status          o_status,
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata
);
    logic [SW-1:0] r_sym;
    t_action       r_act;
    logic          r_is_last;
    logic [CW-1:0] r_node_count;
    logic [NW-1:0] r_last;
    logic [LW-1:0] r_tlen;
    logic [NW-1:0] r_qnode;
    logic          r_qfail;
    logic [PW-1:0] r_plen;
    logic          r_ovf;
    logic [NW-1:0] r_cur, r_p, r_q, r_twin;
    logic [LW-1:0] r_lenp;
    logic [SW-1:0] r_idx;
    logic          r_out_valid;
    logic [PW-1:0] r_out_pos;
    logic          r_out_found;
    logic          r_out_ovf;

    logic           tr_we, tr_re, ln_we, ln_re, lk_we, lk_re, en_we, en_re;
    logic [TAW-1:0] tr_waddr, tr_raddr;
    logic [NW-1:0]  tr_wdata, tr_rdata;
    logic [NW-1:0]  ln_waddr, ln_raddr, lk_waddr, lk_raddr, en_waddr, en_raddr;
    logic [LW-1:0]  ln_wdata, ln_rdata;
    logic [NW-1:0]  lk_wdata, lk_rdata;
    logic [EW-1:0]  en_wdata, en_rdata;
    logic [SW-1:0]  idx_prev;

    assign idx_prev = r_idx - SW'(1);

    safo_ram #(.WIDTH(NW), .DEPTH(1 << TAW)) u_trans (
        .i_clk, .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_re(tr_re), .i_raddr(tr_raddr), .o_rdata(tr_rdata));
    safo_ram #(.WIDTH(LW), .DEPTH(NODE_CAP)) u_len (
        .i_clk, .i_we(ln_we), .i_waddr(ln_waddr), .i_wdata(ln_wdata),
        .i_re(ln_re), .i_raddr(ln_raddr), .o_rdata(ln_rdata));
    safo_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_link (
        .i_clk, .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_re(lk_re), .i_raddr(lk_raddr), .o_rdata(lk_rdata));
    safo_ram #(.WIDTH(EW), .DEPTH(NODE_CAP)) u_end (
        .i_clk, .i_we(en_we), .i_waddr(en_waddr), .i_wdata(en_wdata),
        .i_re(en_re), .i_raddr(en_raddr), .o_rdata(en_rdata));

    // status back to the controller
    always_comb begin
        o_status.act       = r_act;
        o_status.full      = (r_tlen == TEXT_CAP);
        o_status.sym_bad   = (r_sym >= SYM_LIMIT);
        o_status.is_last   = r_is_last;
        o_status.idx_last  = (r_idx == IDX_LAST);
        o_status.copy_done = (r_idx == IDX_COPY);
        o_status.tr_zero   = (tr_rdata == '0);
        o_status.tr_is_q   = (tr_rdata == r_q);
        o_status.p_root    = (r_p == '0);
        o_status.len_match = ((r_lenp + LW'(1)) == ln_rdata);
        o_status.out_busy  = r_out_valid && !i_m_tready;
    end

    // memory port control per command
    always_comb begin
        tr_we = 1'b0; tr_re = 1'b0; ln_we = 1'b0; ln_re = 1'b0;
        lk_we = 1'b0; lk_re = 1'b0; en_we = 1'b0; en_re = 1'b0;
        tr_waddr = {r_p, r_sym};  tr_wdata = r_cur;  tr_raddr = {r_p, r_sym};
        ln_waddr = r_cur; ln_wdata = ln_rdata + LW'(1); ln_raddr = r_p;
        lk_waddr = r_cur; lk_wdata = '0; lk_raddr = r_p;
        en_waddr = r_cur; en_wdata = r_tlen[EW-1:0]; en_raddr = tr_rdata;
        unique case (i_op)
            OP_CLR: begin
                tr_we = 1'b1; tr_waddr = {NW'(0), r_idx}; tr_wdata = '0;
                ln_we = (r_idx == '0); ln_waddr = '0; ln_wdata = '0;
                lk_we = (r_idx == '0); lk_waddr = '0;
                en_we = (r_idx == '0); en_waddr = '0; en_wdata = '0;
            end
            OP_A_INIT: begin
                ln_re = 1'b1; ln_raddr = r_last;
            end
            OP_A_LEN: begin
                ln_we = 1'b1; lk_we = 1'b1; en_we = 1'b1;
            end
            OP_A_ZERO: begin
                tr_we = 1'b1; tr_waddr = {r_cur, r_idx}; tr_wdata = '0;
            end
            OP_W_RD: begin
                tr_re = 1'b1; ln_re = 1'b1;
            end
            OP_W1_SET: begin
                tr_we = 1'b1; lk_re = 1'b1;
            end
            OP_Q_RD: begin
                ln_re = 1'b1; ln_raddr = tr_rdata;
                lk_re = 1'b1; lk_raddr = tr_rdata;
                en_re = 1'b1; en_raddr = tr_rdata;
            end
            OP_LINK_CUR_Q: begin
                lk_we = 1'b1; lk_wdata = r_q;
            end
            OP_C_INIT: begin
                ln_we = 1'b1; ln_waddr = r_node_count[NW-1:0]; ln_wdata = r_lenp + LW'(1);
                lk_we = 1'b1; lk_waddr = r_node_count[NW-1:0]; lk_wdata = lk_rdata;
                en_we = 1'b1; en_waddr = r_node_count[NW-1:0]; en_wdata = en_rdata;
            end
            OP_C_COPY: begin
                tr_re = 1'b1; tr_raddr = {r_q, r_idx};
                tr_we = (r_idx != '0); tr_waddr = {r_twin, idx_prev}; tr_wdata = tr_rdata;
            end
            OP_W2_SET: begin
                tr_we = 1'b1; tr_wdata = r_twin; lk_re = 1'b1;
            end
            OP_FIX_Q: begin
                lk_we = 1'b1; lk_waddr = r_q; lk_wdata = r_twin;
            end
            OP_FIX_CUR: begin
                lk_we = 1'b1; lk_wdata = r_twin;
            end
            OP_P_START: begin
                tr_re = 1'b1; tr_raddr = {r_qnode, r_sym};
            end
            OP_P_NEXT: begin
                en_re = 1'b1; en_raddr = tr_rdata;
            end
            default: begin
            end
        endcase
    end

    // item capture and walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                r_act     <= t_action'(i_s_tdata[1:0]);
                r_sym     <= i_s_tdata[6:2];
                r_is_last <= i_s_tlast;
            end
            OP_A_INIT: begin
                r_cur <= r_node_count[NW-1:0];
                r_p   <= r_last;
            end
            OP_Q_RD: begin
                r_q    <= tr_rdata;
                r_lenp <= ln_rdata;
            end
            OP_P_LINK: r_p <= lk_rdata;
            OP_C_INIT: r_twin <= r_node_count[NW-1:0];
            default: begin
            end
        endcase
    end

    // control state: counts, query state, slot index, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CW'(1);
            r_last       <= '0;
            r_tlen       <= '0;
            r_qnode      <= '0;
            r_qfail      <= 1'b0;
            r_plen       <= '0;
            r_ovf        <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && i_op != OP_P_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_CLR: begin
                    r_node_count <= CW'(1);
                    r_last       <= '0;
                    r_tlen       <= '0;
                    r_qnode      <= '0;
                    r_qfail      <= 1'b0;
                    r_plen       <= '0;
                    r_ovf        <= 1'b0;
                    r_idx        <= (r_idx == IDX_LAST) ? '0 : r_idx + SW'(1);
                end
                OP_SET_OVF: r_ovf <= 1'b1;
                OP_A_INIT:  r_node_count <= r_node_count + CW'(1);
                OP_A_LEN: begin
                    r_last <= r_cur;
                    r_tlen <= r_tlen + LW'(1);
                    r_idx  <= '0;
                end
                OP_A_ZERO: r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + SW'(1);
                OP_C_INIT: begin
                    r_node_count <= r_node_count + CW'(1);
                    r_idx        <= '0;
                end
                OP_C_COPY: r_idx <= (r_idx == IDX_COPY) ? '0 : r_idx + SW'(1);
                OP_P_START: begin
                    if (r_plen != PLEN_MAX) begin
                        r_plen <= r_plen + PW'(1);
                    end
                end
                OP_P_NEXT: begin
                    if (!r_qfail) begin
                        if (r_sym >= SYM_LIMIT || tr_rdata == '0) begin
                            r_qfail <= 1'b1;
                        end else begin
                            r_qnode <= tr_rdata;
                        end
                    end
                end
                OP_P_OUT: begin
                    r_out_valid <= 1'b1;
                    r_qnode     <= '0;
                    r_qfail     <= 1'b0;
                    r_plen      <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_op == OP_P_OUT) begin
            r_out_pos   <= r_qfail ? '0 : (PW'(en_rdata) + PW'(2) - r_plen);
            r_out_found <= !r_qfail;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_ovf, r_out_found, r_out_pos};

    // node and text counts stay within capacity
    a_node_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_count <= CNT_CAP) else $error("node count beyond capacity");
    a_text_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= TEXT_CAP) else $error("text length beyond capacity");
    // a failed walk always has at least one pattern symbol behind it
    a_fail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen == '0 |-> !r_qfail) else $error("failed walk with empty pattern");
endmodule
`default_nettype wire

// ===== rtl/core/safo_ctrl.sv =====
// controller: sequences clear, append, clone and pattern walk steps
`default_nettype none
module safo_ctrl import safo_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_op          o_op
);
    t_state r_state, n_state;

    // state register, reset starts with the root clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NOP;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_op = OP_CLR;
                if (i_status.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_status.act)
                    ACT_CLEAR: n_state = S_CLR;
                    ACT_APPEND: begin
                        if (i_status.full) begin
                            o_op    = OP_SET_OVF;
                            n_state = S_IDLE;
                        end else if (i_status.sym_bad) begin
                            n_state = S_IDLE;
                        end else begin
                            o_op    = OP_A_INIT;
                            n_state = S_A_LEN;
                        end
                    end
                    ACT_PATTERN: begin
                        o_op    = OP_P_START;
                        n_state = S_P_CHK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_A_LEN: begin
                o_op    = OP_A_LEN;
                n_state = S_A_ZERO;
            end
            S_A_ZERO: begin
                o_op = OP_A_ZERO;
                if (i_status.idx_last) n_state = S_W1_RD;
            end
            S_W1_RD: begin
                o_op    = OP_W_RD;
                n_state = S_W1_CHK;
            end
            S_W1_CHK: begin
                if (i_status.tr_zero) begin
                    o_op    = OP_W1_SET;
                    n_state = i_status.p_root ? S_IDLE : S_W1_LINK;
                end else begin
                    o_op    = OP_Q_RD;
                    n_state = S_Q_CHK;
                end
            end
            S_W1_LINK: begin
                o_op    = OP_P_LINK;
                n_state = S_W1_RD;
            end
            S_Q_CHK: begin
                if (i_status.len_match) begin
                    o_op    = OP_LINK_CUR_Q;
                    n_state = S_IDLE;
                end else begin
                    o_op    = OP_C_INIT;
                    n_state = S_C_COPY;
                end
            end
            S_C_COPY: begin
                o_op = OP_C_COPY;
                if (i_status.copy_done) n_state = S_W2_RD;
            end
            S_W2_RD: begin
                o_op    = OP_W_RD;
                n_state = S_W2_CHK;
            end
            S_W2_CHK: begin
                if (i_status.tr_is_q) begin
                    o_op    = OP_W2_SET;
                    n_state = i_status.p_root ? S_FIX_Q : S_W2_LINK;
                end else begin
                    n_state = S_FIX_Q;
                end
            end
            S_W2_LINK: begin
                o_op    = OP_P_LINK;
                n_state = S_W2_RD;
            end
            S_FIX_Q: begin
                o_op    = OP_FIX_Q;
                n_state = S_FIX_CUR;
            end
            S_FIX_CUR: begin
                o_op    = OP_FIX_CUR;
                n_state = S_IDLE;
            end
            S_P_CHK: begin
                o_op    = OP_P_NEXT;
                n_state = i_status.is_last ? S_P_END : S_IDLE;
            end
            S_P_END: begin
                if (!i_status.out_busy) begin
                    o_op    = OP_P_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // items are taken only in idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    // an accepted item is always decoded next
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && i_s_tvalid |=> r_state == S_DEC) else $error("accept not decoded");
    // a result is loaded only when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op == OP_P_OUT |-> !i_status.out_busy) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== rtl/core/suffix_automaton_first_occurrence_top.sv =====
// top level: suffix automaton builder and first-occurrence pattern search
`default_nettype none
// Builds a suffix automaton over appended letters and answers pattern queries
// with the 1-based start of the first occurrence. One item is taken at a time
// from idle, and every item passes through the idle and decode states before
// its own steps. A clear sweeps the 26 root slots of the transition memory;
// the same sweep runs after reset, no item is taken then. An append walks the
// suffix links one step at a time and reads the target node when the walk stops
// on an existing transition; a clone adds the transition copy, the first
// redirect and the link fix-up, plus one check per further link. The copy and
// the sweeps go slot by slot through the single write port of the transition
// memory. A last pattern symbol waits until the output register is free. A
// result may wait in the output register while the next item is taken.
module suffix_automaton_first_occurrence_top import safo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // action[1:0], symbol[6:2], zero[7]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // first_position[12:0], found[13], text_overflow[14], zero[15]
);
    t_op     op;
    t_status status;

    // sequencer
    safo_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready,
        .i_status(status), .o_op(op));

    // stores and registers
    safo_dp u_dp (
        .i_clk, .i_rst_n, .i_op(op), .o_status(status),
        .i_s_tdata, .i_s_tlast, .o_m_tvalid, .i_m_tready, .o_m_tdata);
endmodule
`default_nettype wire
